// File: rtl/egc_pkg.sv
package egc_pkg;

  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_CLASSIFY = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  localparam logic [1:0] CLASS_NONE  = 2'd0;
  localparam logic [1:0] CLASS_SEMI  = 2'd1;
  localparam logic [1:0] CLASS_EULER = 2'd2;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_CHK,
    ST_ADD_WA,
    ST_ADD_WB,
    ST_SWEEP,
    ST_PUSH
  } egc_state_t;

  typedef struct packed {
    logic load_item;
    logic clear;
    logic rd_a;
    logic wr_a;
    logic wr_b;
    logic sweep_start;
    logic sweep_first;
    logic res_load;
    logic out_load;
  } egc_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic sweep_done;
    logic sweep_grew;
    logic out_free;
  } egc_sts_t;

endpackage

// File: rtl/egc_controller.sv
module egc_controller import egc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  egc_sts_t   sts,
  output egc_cmd_t   cmd
);

  egc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_kind)
            KIND_ADD: begin
              state_nxt = ST_ADD_CHK;
            end
            KIND_CLASSIFY: begin
              cmd.sweep_start = 1'b1;
              cmd.sweep_first = 1'b1;
              state_nxt       = ST_SWEEP;
            end
            KIND_CLEAR: begin
              cmd.clear = 1'b1;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADD_CHK: begin
        // drop self-loops and out-of-range endpoints
        if (sts.edge_ok) begin
          cmd.rd_a  = 1'b1;
          state_nxt = ST_ADD_WA;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ADD_WA: begin
        cmd.wr_a  = 1'b1;
        state_nxt = ST_ADD_WB;
      end
      ST_ADD_WB: begin
        cmd.wr_b  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SWEEP: begin
        if (sts.sweep_done) begin
          if (sts.sweep_grew) begin
            cmd.sweep_start = 1'b1;
          end else begin
            cmd.res_load = 1'b1;
            state_nxt    = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/egc_datapath.sv
module egc_datapath import egc_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [5:0] vertex_count,
  input  logic [4:0] in_vertex_a,
  input  logic [4:0] in_vertex_b,
  input  egc_cmd_t   cmd,
  output egc_sts_t   sts,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [1:0] out_graph_class,
  output logic       out_connected,
  output logic [5:0] out_odd_vertices,
  output logic [8:0] out_distinct_edges
);

  localparam int IDXW = $clog2(MAX_VERTICES);
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int DSW  = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) + 1);

  function automatic logic [NW-1:0] popcount(input logic [MAX_VERTICES-1:0] x);
    logic [NW-1:0] cnt;
    cnt = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      cnt = cnt + NW'(x[i]);
    end
    return cnt;
  endfunction

  logic [4:0]              a_r, b_r;
  logic [NW-1:0]           n_eff;
  logic [IDXW-1:0]         n_last;
  logic [MAX_VERTICES-1:0] mask;
  logic [IDXW-1:0]         a_idx, b_idx;

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] mem_q_r;
  logic [MAX_VERTICES-1:0] row_valid_r;
  logic [IDXW-1:0]         raddr, waddr;
  logic [MAX_VERTICES-1:0] wdata;
  logic                    we;

  logic                    issue_r, rd_vld_r, grew_r, first_r;
  logic [IDXW-1:0]         idx_r, rd_idx_r;
  logic [MAX_VERTICES-1:0] reach_r, reach_nxt;
  logic [NW-1:0]           odd_r, odd_nxt;
  logic [DSW-1:0]          deg_r, deg_nxt;
  logic [MAX_VERTICES-1:0] row, new_bits;
  logic [NW-1:0]           deg;
  logic                    count_en, this_grew, done;

  logic [1:0]              res_class_r;
  logic                    res_conn_r;
  logic [5:0]              res_odd_r;
  logic [8:0]              res_edges_r;
  logic                    conn;
  logic [1:0]              cls;

  logic                    out_valid_r;
  logic [1:0]              out_class_r;
  logic                    out_conn_r;
  logic [5:0]              out_odd_r;
  logic [8:0]              out_edges_r;

  always_comb begin
    if (vertex_count == 6'd0) begin
      n_eff = NW'(1);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vertex_count);
    end
  end

  assign n_last = IDXW'(n_eff - NW'(1));

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask[i] = (int'(n_eff) > i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      a_r <= in_vertex_a;
      b_r <= in_vertex_b;
    end
  end

  assign a_idx = IDXW'(a_r);
  assign b_idx = IDXW'(b_r);

  assign sts.edge_ok = (a_r != b_r) && (int'(a_r) < int'(n_eff)) && (int'(b_r) < int'(n_eff));

  // row read port: endpoint rows during an edge add, sweep index otherwise
  always_comb begin
    if (cmd.rd_a) begin
      raddr = a_idx;
    end else if (cmd.wr_a) begin
      raddr = b_idx;
    end else begin
      raddr = idx_r;
    end
  end

  // OR the new bit into the row read last cycle; an unwritten row reads empty
  always_comb begin
    we = cmd.wr_a | cmd.wr_b;
    if (cmd.wr_a) begin
      waddr = a_idx;
      wdata = (row_valid_r[a_idx] ? mem_q_r : '0) | (MAX_VERTICES'(1) << b_idx);
    end else begin
      waddr = b_idx;
      wdata = (row_valid_r[b_idx] ? mem_q_r : '0) | (MAX_VERTICES'(1) << a_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.clear) begin
      row_valid_r <= '0;
    end else if (we) begin
      row_valid_r[waddr] <= 1'b1;
    end
  end

  // sweep: one row per cycle, data arrives in the cycle after its address
  always_comb begin
    row       = (row_valid_r[rd_idx_r] ? mem_q_r : '0) & mask;
    new_bits  = (rd_vld_r && reach_r[rd_idx_r]) ? (row & ~reach_r) : '0;
    reach_nxt = reach_r | new_bits;
    this_grew = |new_bits;
    deg       = popcount(row);
    count_en  = rd_vld_r && first_r;
    odd_nxt   = odd_r + NW'(count_en & deg[0]);
    deg_nxt   = deg_r + (count_en ? DSW'(deg) : DSW'(0));
    done      = rd_vld_r && (rd_idx_r == n_last);
  end

  assign sts.sweep_done = done;
  assign sts.sweep_grew = grew_r | this_grew;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r  <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue_r;
      if (cmd.sweep_start) begin
        issue_r <= 1'b1;
      end else if (issue_r && (idx_r == n_last)) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (cmd.sweep_start) begin
      idx_r   <= '0;
      grew_r  <= 1'b0;
      first_r <= cmd.sweep_first;
    end else begin
      if (issue_r) begin
        idx_r <= idx_r + IDXW'(1);
      end
      grew_r <= grew_r | this_grew;
    end
    if (cmd.sweep_start && cmd.sweep_first) begin
      reach_r <= MAX_VERTICES'(1);
      odd_r   <= '0;
      deg_r   <= '0;
    end else begin
      reach_r <= reach_nxt;
      odd_r   <= odd_nxt;
      deg_r   <= deg_nxt;
    end
  end

  always_comb begin
    conn = (reach_nxt == mask);
    if (conn && (odd_nxt == NW'(0))) begin
      cls = CLASS_EULER;
    end else if (conn && (odd_nxt <= NW'(2))) begin
      cls = CLASS_SEMI;
    end else begin
      cls = CLASS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_class_r <= cls;
      res_conn_r  <= conn;
      res_odd_r   <= 6'(odd_nxt);
      res_edges_r <= 9'(deg_nxt >> 1);
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_class_r <= res_class_r;
      out_conn_r  <= res_conn_r;
      out_odd_r   <= res_odd_r;
      out_edges_r <= res_edges_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_graph_class    = out_class_r;
  assign out_connected      = out_conn_r;
  assign out_odd_vertices   = out_odd_r;
  assign out_distinct_edges = out_edges_r;

endmodule

// File: rtl/eulerian_graph_classifier.sv
// Euler path existence test over an undirected simple graph.
// Input channel (in_valid/in_ready): in_kind 0 adds the edge in_vertex_a -
// in_vertex_b, 1 classifies the stored graph, 2 clears it; kind 3 is ignored.
// Result channel (out_valid/out_ready): one item per classify, carrying class,
// connectivity, odd-degree vertex count and distinct edge count.
// APB port: register 0 at byte 0 is vertex_count (1..MAX_VERTICES used).
// Sequencing: an add checks the edge, then reads and rewrites both endpoint
// rows in turn through the row memory's read port and write port; a dropped
// edge ends after the check. A clear resets the per-row valid bits.
// A classify walks the matrix one row per cycle; reachability sweeps repeat
// until the reached set stops growing (1 to n sweeps), degrees are counted in
// the first sweep, and the result passes a result register to the output.
// Reset empties the graph (per-row valid bits, no clearing pass), sets
// vertex_count to 32 and drops any pending result.
// A stalled receiver holds the result in the output register; adds and clears
// are still taken, and a further classify waits before delivering its result.
module eulerian_graph_classifier import egc_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [4:0]  in_vertex_a,
  input  logic [4:0]  in_vertex_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_graph_class,
  output logic        out_connected,
  output logic [5:0]  out_odd_vertices,
  output logic [8:0]  out_distinct_edges,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0] vertex_count_r;
  egc_cmd_t   cmd;
  egc_sts_t   sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= 6'd32;
    end else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT)) begin
      vertex_count_r <= pwdata[5:0];
    end
  end

  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {26'd0, vertex_count_r} : 32'd0;

  egc_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  egc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .vertex_count       (vertex_count_r),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_graph_class    (out_graph_class),
    .out_connected      (out_connected),
    .out_odd_vertices   (out_odd_vertices),
    .out_distinct_edges (out_distinct_edges)
  );

endmodule
